// ----- rtl/trilinear_volume_interpolator_defines.svh -----
// assertion macros shared by the interpolator rtl
`ifndef TRILINEAR_VOLUME_INTERPOLATOR_DEFINES_SVH
`define TRILINEAR_VOLUME_INTERPOLATOR_DEFINES_SVH
`ifndef SYNTHESIS
// checked property, idle while reset is asserted
`define TVI_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked property, also sampled through reset
`define TVI_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TVI_ASSERT(label, prop, msg)
`define TVI_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ----- rtl/tvi_pkg.sv -----
// package: types, constants and register indexes of the volume interpolator
`timescale 1ns / 1ps
package tvi_pkg;
	localparam int DIM_ROWS_DEF   = 32;
	localparam int DIM_COLS_DEF   = 32;
	localparam int DIM_SLICES_DEF = 32;
	localparam int STORE_AW       = 15;
	localparam int SAMPLE_W       = 16;
	localparam int IDX_W          = 10;
	localparam int FRAC_W         = 16;
	localparam int WGT_W          = 17;
	localparam int CFG_W          = 32;
	localparam int OUT_W          = 24;
	localparam logic [WGT_W-1:0] ONE_Q16 = 17'h10000;

	typedef enum logic [2:0] {
		REG_SCALE_X  = 3'd0,
		REG_OFFSET_X = 3'd1,
		REG_SCALE_Y  = 3'd2,
		REG_OFFSET_Y = 3'd3,
		REG_SCALE_Z  = 3'd4,
		REG_OFFSET_Z = 3'd5
	} reg_idx_t;

	localparam logic signed [CFG_W-1:0] SCALE_RST  = 32'sh0001_0000;
	localparam logic signed [CFG_W-1:0] OFFSET_RST = 32'sh0000_0000;

	// clamped neighbour indices and fraction of one axis
	typedef struct packed {
		logic [IDX_W-1:0]  i0;
		logic [IDX_W-1:0]  i1;
		logic [FRAC_W-1:0] frac;
	} axis_t;
endpackage

// ----- rtl/tvi_axis_map.sv -----
// one axis: scale*coord+offset, floor, fraction and edge clamp, two stages
`timescale 1ns / 1ps
module tvi_axis_map #(
	parameter int DIM = tvi_pkg::DIM_ROWS_DEF
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [tvi_pkg::CFG_W-1:0]  coord,
	input  logic signed [tvi_pkg::CFG_W-1:0]  scale,
	input  logic signed [tvi_pkg::CFG_W-1:0]  offset,
	output tvi_pkg::axis_t                    axis
);
	localparam logic signed [32:0] DIM_MAX = 33'(DIM - 1);

	logic signed [63:0] prod_s1;
	logic signed [63:0] pos;
	logic signed [32:0] g0;
	logic signed [32:0] g1;
	tvi_pkg::axis_t     axis_s2;

	function automatic logic [tvi_pkg::IDX_W-1:0] clamp(input logic signed [32:0] v);
		logic [tvi_pkg::IDX_W-1:0] r;
		if (v < 0) r = '0;
		else if (v > DIM_MAX) r = tvi_pkg::IDX_W'(DIM_MAX);
		else r = v[tvi_pkg::IDX_W-1:0];
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (en) prod_s1 <= 64'(coord) * 64'(scale);
	end

	always_comb begin
		pos = prod_s1 + {{16{offset[31]}}, offset, 16'h0000};
		g1  = {pos[63], pos[63:32]};
		g0  = g1 - 33'sd1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			axis_s2.i0   <= clamp(g0);
			axis_s2.i1   <= clamp(g1);
			axis_s2.frac <= pos[31:16];
		end
	end

	assign axis = axis_s2;
endmodule

// ----- rtl/tvi_bank.sv -----
// one copy of the sample volume: one write port, one registered read port
`timescale 1ns / 1ps
module tvi_bank (
	input  logic                                clk,
	input  logic                                we,
	input  logic [tvi_pkg::STORE_AW-1:0]        waddr,
	input  logic signed [tvi_pkg::SAMPLE_W-1:0] wdata,
	input  logic                                re,
	input  logic [tvi_pkg::STORE_AW-1:0]        raddr,
	output logic signed [tvi_pkg::SAMPLE_W-1:0] rdata
);
	logic signed [tvi_pkg::SAMPLE_W-1:0] mem [2**tvi_pkg::STORE_AW];
	logic signed [tvi_pkg::SAMPLE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re) rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ----- rtl/tvi_blend.sv -----
// weighted sum of the eight neighbours, rounding and result register
`timescale 1ns / 1ps
module tvi_blend (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                vld_in,
	input  logic signed [tvi_pkg::SAMPLE_W-1:0] samp [8],
	input  logic [2*tvi_pkg::WGT_W-1:0]         wxy [4],
	input  logic [tvi_pkg::WGT_W-1:0]           wz [2],
	output logic                                vld_out,
	output logic signed [tvi_pkg::OUT_W-1:0]    value
);
	logic signed [33:0]               mz_s4 [8];
	logic [2*tvi_pkg::WGT_W-1:0]      wxy_s4 [4];
	logic signed [63:0]               p_s5 [8];
	logic signed [63:0]               pair_s6 [4];
	logic                             vld_s4, vld_s5, vld_s6, vld_q;
	logic signed [tvi_pkg::OUT_W-1:0] value_q;
	logic [63:0]                      total;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 8; i++) begin
				mz_s4[i] <= 34'(samp[i]) * $signed({17'h0, wz[i/4]});
				// full 64-bit product, sample times all three weights
				p_s5[i]  <= mz_s4[i] * $signed({1'b0, wxy_s4[i%4]});
			end
			for (int j = 0; j < 4; j++) begin
				wxy_s4[j]  <= wxy[j];
				pair_s6[j] <= p_s5[2*j] + p_s5[2*j+1];
			end
		end
	end

	// round half up to q.8
	assign total = 64'(pair_s6[0] + pair_s6[1] + pair_s6[2] + pair_s6[3]) + (64'd1 << 39);

	always_ff @(posedge clk) begin
		if (en) value_q <= total[63:40];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_q  <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_in;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_q  <= vld_s6;
		end
	end

	assign vld_out = vld_q;
	assign value   = value_q;
endmodule

// ----- rtl/trilinear_volume_interpolator.sv -----
// top level: trilinear interpolation over a stored 3-d sample volume
`timescale 1ns / 1ps
`include "trilinear_volume_interpolator_defines.svh"
// usage
// - slave stream carries one request per beat; tuser = op (0 write voxel,
//   1 query). tdata holds voxel_addr, voxel_value, coord_x, coord_y, coord_z
// - a write request stores voxel_value at voxel_addr and gives no result
// - a query request gives one master-stream beat with interp_value (q15.8)
// - cfg_we/cfg_index/cfg_data write the six q16.16 scale and offset registers;
//   write them only while no request is in flight
// throughput: one request per clock while the master side does not stall, writes and queries mixed freely
// - two stages map the axes (one 32x32 multiply, then add, floor and clamp)
// - the eight neighbour samples come from eight copies of the volume, each
//   read once per clock, so all neighbours arrive together
// - four stages blend, the last one is the result register
// writes pass down the same pipe and reach the memories in the read stage, so
// a query always sees exactly the writes accepted before it
// reset clears the valid bits and sets the config registers to unit scale and
// zero offset; the volume holds nothing valid until written
// a stalled master side freezes the whole pipe; tready of the slave side
// stays high while the result register is empty or being taken
module trilinear_volume_interpolator #(
	parameter int DIM_ROWS   = tvi_pkg::DIM_ROWS_DEF,
	parameter int DIM_COLS   = tvi_pkg::DIM_COLS_DEF,
	parameter int DIM_SLICES = tvi_pkg::DIM_SLICES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// voxel_addr[14:0], voxel_value[30:15], coord_x[62:31], coord_y[94:63],
	// coord_z[126:95], zero pad [127]
	input  logic [127:0] s_tdata,
	// op
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// interp_value[23:0]
	output logic [23:0]  m_tdata,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	localparam int AW = tvi_pkg::STORE_AW;
	localparam int SW = tvi_pkg::SAMPLE_W;
	localparam int WW = tvi_pkg::WGT_W;

	// configuration registers
	logic signed [31:0] scale_x_q, offset_x_q, scale_y_q, offset_y_q, scale_z_q, offset_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_x_q  <= tvi_pkg::SCALE_RST;
			offset_x_q <= tvi_pkg::OFFSET_RST;
			scale_y_q  <= tvi_pkg::SCALE_RST;
			offset_y_q <= tvi_pkg::OFFSET_RST;
			scale_z_q  <= tvi_pkg::SCALE_RST;
			offset_z_q <= tvi_pkg::OFFSET_RST;
		end else if (cfg_we) begin
			// unknown indexes are dropped
			case (tvi_pkg::reg_idx_t'(cfg_index))
				tvi_pkg::REG_SCALE_X:  scale_x_q  <= cfg_data;
				tvi_pkg::REG_OFFSET_X: offset_x_q <= cfg_data;
				tvi_pkg::REG_SCALE_Y:  scale_y_q  <= cfg_data;
				tvi_pkg::REG_OFFSET_Y: offset_y_q <= cfg_data;
				tvi_pkg::REG_SCALE_Z:  scale_z_q  <= cfg_data;
				tvi_pkg::REG_OFFSET_Z: offset_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// whole pipe moves when the result register can take a new value
	logic adv;
	logic accept;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;
	assign accept   = s_tvalid && adv;

	// request control and write payload through the mapping stages
	logic vld_s1, qry_s1, vld_s2, qry_s2, vld_s3;
	logic [AW-1:0]        waddr_s1, waddr_s2;
	logic signed [SW-1:0] wval_s1, wval_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2 && qry_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			qry_s1   <= s_tuser;
			waddr_s1 <= s_tdata[14:0];
			wval_s1  <= s_tdata[30:15];
			qry_s2   <= qry_s1;
			waddr_s2 <= waddr_s1;
			wval_s2  <= wval_s1;
		end
	end

	// per-axis mapping, x = column, y = row, z = slice
	tvi_pkg::axis_t ax_x, ax_y, ax_z;

	tvi_axis_map #(.DIM(DIM_COLS)) u_map_x (
		.clk(clk), .en(adv), .coord(s_tdata[62:31]),
		.scale(scale_x_q), .offset(offset_x_q), .axis(ax_x)
	);
	tvi_axis_map #(.DIM(DIM_ROWS)) u_map_y (
		.clk(clk), .en(adv), .coord(s_tdata[94:63]),
		.scale(scale_y_q), .offset(offset_y_q), .axis(ax_y)
	);
	tvi_axis_map #(.DIM(DIM_SLICES)) u_map_z (
		.clk(clk), .en(adv), .coord(s_tdata[126:95]),
		.scale(scale_z_q), .offset(offset_z_q), .axis(ax_z)
	);

	// neighbour addresses, wrapped to the store width
	logic [AW-1:0] raddr [8];
	logic [AW-1:0] rx, ry, rz;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			rx = AW'(i[0] ? ax_x.i1 : ax_x.i0);
			ry = AW'(i[1] ? ax_y.i1 : ax_y.i0);
			rz = AW'(i[2] ? ax_z.i1 : ax_z.i0);
			raddr[i] = ry + AW'(DIM_ROWS) * (rx + AW'(DIM_COLS) * rz);
		end
	end

	logic mem_we, mem_re;
	assign mem_we = adv && vld_s2 && !qry_s2;
	assign mem_re = adv && vld_s2 && qry_s2;

	logic signed [SW-1:0] samp_s3 [8];

	for (genvar b = 0; b < 8; b++) begin : g_bank
		tvi_bank u_bank (
			.clk(clk), .we(mem_we), .waddr(waddr_s2), .wdata(wval_s2),
			.re(mem_re), .raddr(raddr[b]), .rdata(samp_s3[b])
		);
	end

	// weights, stage 3 alongside the memory read
	logic [WW-1:0]   wx0, wy0;
	logic [2*WW-1:0] wxy_s3 [4];
	logic [WW-1:0]   wz_s3 [2];

	assign wx0 = tvi_pkg::ONE_Q16 - WW'(ax_x.frac);
	assign wy0 = tvi_pkg::ONE_Q16 - WW'(ax_y.frac);

	always_ff @(posedge clk) begin
		if (adv) begin
			wxy_s3[0] <= wx0 * wy0;
			wxy_s3[1] <= WW'(ax_x.frac) * wy0;
			wxy_s3[2] <= wx0 * WW'(ax_y.frac);
			wxy_s3[3] <= WW'(ax_x.frac) * WW'(ax_y.frac);
			wz_s3[0]  <= tvi_pkg::ONE_Q16 - WW'(ax_z.frac);
			wz_s3[1]  <= WW'(ax_z.frac);
		end
	end

	logic signed [tvi_pkg::OUT_W-1:0] result;

	tvi_blend u_blend (
		.clk(clk), .arst_n(arst_n), .en(adv), .vld_in(vld_s3),
		.samp(samp_s3), .wxy(wxy_s3), .wz(wz_s3),
		.vld_out(m_tvalid), .value(result)
	);

	assign m_tdata = result;

	// checks
	`TVI_ASSERT_ALWAYS(a_mem_excl, !(mem_we && mem_re), "memory read and write in one cycle")
	`TVI_ASSERT(a_req_enters, accept |=> vld_s1, "accepted request missing in stage one")
	`TVI_ASSERT(a_hold_stall, !adv |=> ($stable(vld_s1) && $stable(vld_s2) && $stable(vld_s3)),
		"pipe moved while stalled")
	`TVI_ASSERT(a_write_silent, (vld_s2 && !qry_s2 && adv) |=> !vld_s3,
		"voxel write produced a result")
endmodule

// ----- verif/trilinear_volume_interpolator_tb.sv -----
// testbench: trilinear volume interpolator, predicted result stream checked beat by beat
`timescale 1ns / 1ps
module trilinear_volume_interpolator_tb;
	localparam int  DIM_R       = tvi_pkg::DIM_ROWS_DEF;
	localparam int  DIM_C       = tvi_pkg::DIM_COLS_DEF;
	localparam int  DIM_S       = tvi_pkg::DIM_SLICES_DEF;
	localparam int  DEPTH       = 1 << tvi_pkg::STORE_AW;
	localparam int  CYCLE_LIMIT = 400000;
	localparam int  PIPE_SETTLE = 12;
	// loaded grid lines per axis: the lowest three and the top two
	localparam int  LOAD_LOW    = 3;
	localparam int  LOAD_SLOTS  = 5;
	localparam int  PICK_TRIES  = 64;
	// codes on tuser
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;
	// index values outside the register map, writes to them are dropped
	localparam logic [2:0] REG_SPARE_A = 3'd6;
	localparam logic [2:0] REG_SPARE_B = 3'd7;
	localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
	localparam logic signed [31:0] S_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] S_MIN = 32'sh8000_0000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata = '0;
	logic         s_tuser = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [23:0]  m_tdata;
	logic         cfg_we = 1'b0;
	logic [2:0]   cfg_index = '0;
	logic [31:0]  cfg_data = '0;

	// local copy of the volume and the mapping registers
	logic signed [15:0] volume_copy [0:DEPTH-1];
	logic signed [31:0] mapping_regs [0:5];
	// interpolated values still owed by the block, oldest first
	logic [23:0] pending_values[$];

	int unsigned cycle_count = 0;
	int unsigned mismatch_count = 0;
	int unsigned results_seen = 0;
	int unsigned writes_sent = 0;
	int unsigned queries_sent = 0;
	int unsigned settings_run = 0;
	bit          tx_gaps = 1'b0;
	bit          rx_gaps = 1'b0;
	int unsigned rx_wait = 0;
	int unsigned hold_off = 0;

	trilinear_volume_interpolator DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// hard stop if the pipe hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results owed", cycle_count,
				pending_values.size());
			$display("FAILURE");
			$finish;
		end
	end

	// map one axis: two clamped neighbour indices and the 16-bit fraction
	function automatic tvi_pkg::axis_t map_axis(input logic signed [31:0] coord,
			input logic signed [31:0] scale, input logic signed [31:0] offset,
			input int dim);
		logic signed [63:0] pos;
		logic signed [63:0] grid;
		tvi_pkg::axis_t a;
		pos = scale * coord;
		pos = pos + offset * 64'sd65536;
		// q32.32 position, integer part moved to 0-based
		grid = (pos >>> 32) - 1;
		a.frac = pos[31:16];
		a.i0 = (grid < 0) ? '0 : (grid > dim - 1) ? tvi_pkg::IDX_W'(dim - 1)
			: tvi_pkg::IDX_W'(grid);
		a.i1 = (grid + 1 < 0) ? '0 : (grid + 1 > dim - 1) ? tvi_pkg::IDX_W'(dim - 1)
			: tvi_pkg::IDX_W'(grid + 1);
		return a;
	endfunction

	// grid line of load slot k on one axis
	function automatic int load_idx(input int k, input int dim);
		return (k < LOAD_LOW) ? k : dim - LOAD_SLOTS + k;
	endfunction

	// true when grid line i of one axis has been loaded
	function automatic bit idx_loaded(input logic [tvi_pkg::IDX_W-1:0] i, input int dim);
		return (int'(i) < LOAD_LOW) || (int'(i) >= dim - (LOAD_SLOTS - LOAD_LOW));
	endfunction

	// weighted sum of the eight neighbours, rounded half up to q15.8
	function automatic logic [23:0] interpolate_point(input logic signed [31:0] px,
			input logic signed [31:0] py, input logic signed [31:0] pz);
		tvi_pkg::axis_t ax, ay, az;
		logic [63:0] wx [2];
		logic [63:0] wy [2];
		logic [63:0] wz [2];
		logic [tvi_pkg::IDX_W-1:0] xi [2];
		logic [tvi_pkg::IDX_W-1:0] yi [2];
		logic [tvi_pkg::IDX_W-1:0] zi [2];
		logic [63:0] acc;
		logic [63:0] smp;
		logic [31:0] addr;
		ax = map_axis(px, mapping_regs[tvi_pkg::REG_SCALE_X],
			mapping_regs[tvi_pkg::REG_OFFSET_X], DIM_C);
		ay = map_axis(py, mapping_regs[tvi_pkg::REG_SCALE_Y],
			mapping_regs[tvi_pkg::REG_OFFSET_Y], DIM_R);
		az = map_axis(pz, mapping_regs[tvi_pkg::REG_SCALE_Z],
			mapping_regs[tvi_pkg::REG_OFFSET_Z], DIM_S);
		wx[0] = 64'(tvi_pkg::ONE_Q16) - 64'(ax.frac); wx[1] = 64'(ax.frac);
		wy[0] = 64'(tvi_pkg::ONE_Q16) - 64'(ay.frac); wy[1] = 64'(ay.frac);
		wz[0] = 64'(tvi_pkg::ONE_Q16) - 64'(az.frac); wz[1] = 64'(az.frac);
		xi[0] = ax.i0; xi[1] = ax.i1;
		yi[0] = ay.i0; yi[1] = ay.i1;
		zi[0] = az.i0; zi[1] = az.i1;
		acc = '0;
		// exact q.48 sum, modulo 2^64
		for (int c = 0; c < 2; c++)
			for (int b = 0; b < 2; b++)
				for (int a = 0; a < 2; a++) begin
					addr = yi[b] + DIM_R * (xi[a] + DIM_C * zi[c]);
					smp = 64'(volume_copy[addr[tvi_pkg::STORE_AW-1:0]]);
					acc = acc + smp * (wx[a] * wy[b] * wz[c]);
				end
		acc = acc + (64'd1 << 39);
		return acc[63:40];
	endfunction

	// one request on the slave stream; left valid so back-to-back requests stay valid
	task automatic send_request(input logic op, input logic [14:0] addr,
			input logic signed [15:0] value, input logic signed [31:0] px,
			input logic signed [31:0] py, input logic signed [31:0] pz);
		int unsigned gap;
		gap = tx_gaps ? $urandom_range(0, 7) : 0;
		repeat (gap) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = op;
		s_tdata = {1'b0, pz, py, px, value, addr};
		do @(posedge clk); while (!s_tready);
		if (op == OP_WRITE) begin
			volume_copy[addr] = value;
			writes_sent++;
		end else begin
			pending_values.push_back(interpolate_point(px, py, pz));
			queries_sent++;
		end
		@(negedge clk);
	endtask

	// drop valid, let every owed result come back and the pipe empty
	task automatic wait_idle();
		s_tvalid = 1'b0;
		while (pending_values.size() != 0) @(negedge clk);
		repeat (PIPE_SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic signed [31:0] value);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		if (idx <= tvi_pkg::REG_OFFSET_Z)
			mapping_regs[idx] = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_mapping(input logic signed [31:0] sx, input logic signed [31:0] ox,
			input logic signed [31:0] sy, input logic signed [31:0] oy,
			input logic signed [31:0] sz, input logic signed [31:0] oz);
		wait_idle();
		write_reg(tvi_pkg::REG_SCALE_X, sx);
		write_reg(tvi_pkg::REG_OFFSET_X, ox);
		write_reg(tvi_pkg::REG_SCALE_Y, sy);
		write_reg(tvi_pkg::REG_OFFSET_Y, oy);
		write_reg(tvi_pkg::REG_SCALE_Z, sz);
		write_reg(tvi_pkg::REG_OFFSET_Z, oz);
		settings_run++;
	endtask

	// mostly inside or just around the grid, sometimes anywhere
	function automatic logic signed [31:0] pick_coord();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? S_MAX : S_MIN;
			2: return -$signed({1'b0, 31'($urandom_range(0, 4 * 65536))});
			default: return $urandom_range(0, 34 * 65536);
		endcase
	endfunction

	// a coordinate whose two neighbours on this axis are both loaded
	function automatic bit pick_axis_coord(input logic signed [31:0] scale,
			input logic signed [31:0] offset, input int dim,
			output logic signed [31:0] coord);
		tvi_pkg::axis_t a;
		logic signed [31:0] c;
		coord = '0;
		for (int t = 0; t < PICK_TRIES; t++) begin
			c = pick_coord();
			a = map_axis(c, scale, offset, dim);
			if (idx_loaded(a.i0, dim) && idx_loaded(a.i1, dim)) begin
				coord = c;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// a query that finds no point on loaded voxels goes out as a voxel write
	task automatic send_random_mix(input int unsigned count, input int unsigned write_pct);
		logic signed [31:0] px, py, pz;
		bit ok;
		for (int unsigned n = 0; n < count; n++) begin
			ok = 1'b0;
			if ($urandom_range(0, 99) >= write_pct) begin
				ok = pick_axis_coord(mapping_regs[tvi_pkg::REG_SCALE_X],
					mapping_regs[tvi_pkg::REG_OFFSET_X], DIM_C, px);
				if (ok)
					ok = pick_axis_coord(mapping_regs[tvi_pkg::REG_SCALE_Y],
						mapping_regs[tvi_pkg::REG_OFFSET_Y], DIM_R, py);
				if (ok)
					ok = pick_axis_coord(mapping_regs[tvi_pkg::REG_SCALE_Z],
						mapping_regs[tvi_pkg::REG_OFFSET_Z], DIM_S, pz);
			end
			if (ok)
				send_request(OP_QUERY, 15'($urandom), 16'($urandom), px, py, pz);
			else
				send_request(OP_WRITE, 15'($urandom), 16'($urandom), $urandom, $urandom,
					$urandom);
		end
	endtask

	// receiver: long hold-off first, then per-result random stalls
	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 1'b0;
		end else if (rx_wait > 0) begin
			rx_wait <= rx_wait - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			rx_wait <= rx_gaps ? $urandom_range(0, 7) : 0;
			if (pending_values.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result %h at cycle %0d", m_tdata, cycle_count);
			end else begin
				if (m_tdata !== pending_values[0]) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("interp_value mismatch: expected %h got %h (result %0d)",
							pending_values[0], m_tdata, results_seen);
				end
				void'(pending_values.pop_front());
			end
		end
	end

	// the low three and top two grid lines of every axis get a value before any
	// query, four of the corners take the extremes
	task automatic test_volume_load();
		logic [31:0] addr;
		logic signed [15:0] v;
		tx_gaps = 1'b0;
		for (int s = 0; s < LOAD_SLOTS; s++)
			for (int c = 0; c < LOAD_SLOTS; c++)
				for (int r = 0; r < LOAD_SLOTS; r++) begin
					addr = load_idx(r, DIM_R) + DIM_R * (load_idx(c, DIM_C)
						+ DIM_C * load_idx(s, DIM_S));
					v = 16'($urandom);
					if (addr == 0) v = 16'sh7fff;
					if (addr == DEPTH - 1) v = 16'sh8000;
					if (addr == DIM_R - 1) v = 16'sh8000;
					if (addr == DIM_R * DIM_C - 1) v = 16'sh7fff;
					send_request(OP_WRITE, addr[tvi_pkg::STORE_AW-1:0], v, $urandom,
						$urandom, $urandom);
				end
		wait_idle();
	endtask

	// grid points, halves, far outside and the field extremes at reset mapping
	task automatic test_directed_points();
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		// exact first voxel and last voxel
		send_request(OP_QUERY, '0, '0, Q_ONE, Q_ONE, Q_ONE);
		send_request(OP_QUERY, '0, '0, 32 * Q_ONE, 32 * Q_ONE, 32 * Q_ONE);
		// half way on each axis, rounding of halves
		send_request(OP_QUERY, 15'h7fff, 16'sh7fff, 32'sh0001_8000, Q_ONE, Q_ONE);
		send_request(OP_QUERY, '0, '0, 32'sh0001_8000, 32'sh0001_8000, 32'sh0001_8000);
		// fraction all ones, low and top of the grid
		send_request(OP_QUERY, '0, '0, 32'sh0002_ffff, 32'sh001f_ffff, 32'sh0000_ffff);
		// outside: below, above, coordinate extremes
		send_request(OP_QUERY, '0, '0, '0, '0, '0);
		send_request(OP_QUERY, '0, '0, S_MIN, S_MIN, S_MIN);
		send_request(OP_QUERY, '0, '0, S_MAX, S_MAX, S_MAX);
		send_request(OP_QUERY, '0, '0, S_MIN, S_MAX, 32'sh001f_4000);
		send_request(OP_QUERY, '0, '0, 32'shffff_ffff, 32'sh0021_0000, 32'sh0000_8000);
		// write with busy coordinate fields, then read it back straight away
		send_request(OP_WRITE, 15'd33, 16'sh8000, S_MAX, S_MIN, 32'shffff_ffff);
		send_request(OP_QUERY, 15'h7fff, 16'shffff, 32'sh0002_0000, 32'sh0002_0000, Q_ONE);
		send_request(OP_WRITE, 15'd33, 16'sh7fff, '0, '0, '0);
		send_request(OP_QUERY, '0, '0, 32'sh0002_0000, 32'sh0002_0000, Q_ONE);
		send_request(OP_QUERY, '0, '0, 32'sh0001_c000, 32'sh0002_4000, 32'sh0001_2000);
		wait_idle();
	endtask

	// several mappings, extremes among them, random traffic under each, then unit mapping again
	task automatic test_mapping_sweep();
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		set_mapping(S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN);
		send_random_mix(20, 10);
		set_mapping(S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX);
		send_random_mix(20, 10);
		// zero scale, offset alone picks the point
		set_mapping('0, 32'sh001f_8000, '0, 32'sh0001_4000, '0, 32'sh0020_c000);
		send_random_mix(15, 10);
		// mirrored x and z axes, halved y scale
		set_mapping(-Q_ONE, 33 * Q_ONE, Q_ONE / 2, Q_ONE, -2 * Q_ONE, 20 * Q_ONE);
		send_random_mix(30, 20);
		set_mapping($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		send_random_mix(20, 20);
		// indexes outside the map must leave the mapping untouched
		wait_idle();
		write_reg(REG_SPARE_A, S_MIN);
		write_reg(REG_SPARE_B, S_MAX);
		send_random_mix(15, 20);
		set_mapping(Q_ONE, '0, Q_ONE, '0, Q_ONE, '0);
	endtask

	// random stream at unit mapping, gap settings changing between runs
	task automatic test_random_stream();
		for (int run = 0; run < 6; run++) begin
			tx_gaps = run[0];
			rx_gaps = run[1] ^ run[2];
			send_random_mix(20, 25);
		end
	endtask

	// receiver holds off while requests keep coming, then a paused sender
	task automatic test_backpressure();
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		hold_off = 150;
		send_random_mix(40, 10);
		wait_idle();
		rx_gaps = 1'b1;
		send_random_mix(20, 30);
		wait_idle();
		tx_gaps = 1'b1;
		send_random_mix(20, 30);
	endtask

	initial begin
		for (int i = 0; i < 6; i++)
			mapping_regs[i] = i[0] ? tvi_pkg::OFFSET_RST : tvi_pkg::SCALE_RST;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_volume_load();
		test_directed_points();
		test_mapping_sweep();
		test_random_stream();
		test_backpressure();
		wait_idle();
		$display("%0d voxel writes, %0d queries, %0d results checked", writes_sent,
			queries_sent, results_seen);
		$display("%0d mappings incl. extremes, gaps and a long receiver hold-off",
			settings_run);
		if (mismatch_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("FAILURE");
		end
		$finish;
	end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/tvi_pkg.sv
rtl/tvi_axis_map.sv
rtl/tvi_bank.sv
rtl/tvi_blend.sv
rtl/trilinear_volume_interpolator.sv
verif/trilinear_volume_interpolator_tb.sv
